@@ rtl/core/rfw_pkg.sv @@
package rfw_pkg;

    // Value format: signed Q16.16
    localparam int VALUE_WIDTH = 32;
    localparam int DIV_STEPS   = VALUE_WIDTH;
    localparam int CNT_W       = $clog2(DIV_STEPS);

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_WRAP_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOUND_A   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOUND_B   = 2'd2;

    // Reset values of the bounds (bound_b defaults to 1.0)
    localparam logic signed [VALUE_WIDTH-1:0] BOUND_A_RESET = 32'sh0000_0000;
    localparam logic signed [VALUE_WIDTH-1:0] BOUND_B_RESET = 32'sh0001_0000;

    // Operation codes
    localparam logic OP_MAP    = 1'b0;
    localparam logic OP_REPEAT = 1'b1;

    typedef struct packed {
        logic                          operation;
        logic signed [VALUE_WIDTH-1:0] sample_in;
    } in_item_t;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] sample_out;
        logic                          zero_span;
    } out_item_t;

    // Controller to datapath
    typedef struct packed {
        logic load_in;
        logic setup;
        logic div_step;
        logic publish;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic needs_div;
    } stat_t;

endpackage

@@ rtl/core/rfw_ctrl.sv @@
module rfw_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  rfw_pkg::stat_t stat,
    output rfw_pkg::cmd_t  cmd
);
    import rfw_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SETUP = 2'd1;
    localparam logic [1:0] S_DIV   = 2'd2;
    localparam logic [1:0] S_OUT   = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_SETUP;
                end
            end
            S_SETUP:
            begin
                cmd.setup = 1'b1;
                cnt_next  = '0;
                state_next = stat.needs_div ? S_DIV : S_OUT;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                // output register free or draining this cycle
                if (!out_valid_reg || out_ready)
                begin
                    cmd.publish    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

@@ rtl/core/rfw_dpath.sv @@
module rfw_dpath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  rfw_pkg::in_item_t              in_data,
    output rfw_pkg::out_item_t             out_data,
    input  logic                           cfg_we,
    input  logic [rfw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rfw_pkg::VALUE_WIDTH-1:0] cfg_wdata,
    input  rfw_pkg::cmd_t                  cmd,
    output rfw_pkg::stat_t                 stat
);
    import rfw_pkg::*;

    // configuration
    logic                          wrap_mode_reg;
    logic signed [VALUE_WIDTH-1:0] bound_a_reg;
    logic signed [VALUE_WIDTH-1:0] bound_b_reg;

    // request and working registers
    logic                          op_reg;
    logic signed [VALUE_WIDTH-1:0] sample_reg;
    logic signed [VALUE_WIDTH-1:0] lo_reg, hi_reg;
    logic        [VALUE_WIDTH-1:0] span_reg;
    logic                          below_reg;
    logic signed [VALUE_WIDTH-1:0] direct_reg;
    logic                          flag_reg;
    logic                          use_div_reg;
    logic        [VALUE_WIDTH-1:0] dvd_reg, dvd_next;
    logic        [VALUE_WIDTH-1:0] rem_reg, rem_next;
    logic                          qbit_reg, qbit_next;
    logic signed [VALUE_WIDTH-1:0] last_reg;
    out_item_t                     out_reg, out_next;

    // setup terms
    logic                          swap;
    logic signed [VALUE_WIDTH-1:0] lo_c, hi_c;
    logic        [VALUE_WIDTH-1:0] span_c;
    logic                          below_c, above_c, outside_c;
    logic        [VALUE_WIDTH-1:0] dist_c;

    // divider step
    logic [VALUE_WIDTH:0] trial;
    logic [VALUE_WIDTH:0] diff;

    // final result
    logic                          take_hi;
    logic signed [VALUE_WIDTH-1:0] div_res;

    // configuration writes; other indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrap_mode_reg <= 1'b0;
            bound_a_reg   <= BOUND_A_RESET;
            bound_b_reg   <= BOUND_B_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WRAP_MODE: wrap_mode_reg <= cfg_wdata[0];
                REG_BOUND_A:   bound_a_reg   <= cfg_wdata;
                REG_BOUND_B:   bound_b_reg   <= cfg_wdata;
                default:       ;
            endcase
        end
    end

    // order the bounds, classify the sample
    always_comb
    begin
        swap      = bound_b_reg < bound_a_reg;
        lo_c      = swap ? bound_b_reg : bound_a_reg;
        hi_c      = swap ? bound_a_reg : bound_b_reg;
        span_c    = hi_c - lo_c;
        below_c   = sample_reg < lo_c;
        above_c   = hi_c < sample_reg;
        outside_c = below_c || above_c;
        dist_c    = below_c ? (lo_c - sample_reg) : (sample_reg - hi_c);
    end

    assign stat.needs_div = (op_reg == OP_MAP) && outside_c && (span_c != '0);

    // restoring remainder, one quotient bit per step
    always_comb
    begin
        trial     = {rem_reg, dvd_reg[VALUE_WIDTH-1]};
        diff      = trial - {1'b0, span_reg};
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        qbit_next = qbit_reg;
        if (cmd.setup)
        begin
            dvd_next  = dist_c;
            rem_next  = '0;
            qbit_next = 1'b0;
        end
        else if (cmd.div_step)
        begin
            dvd_next = {dvd_reg[VALUE_WIDTH-2:0], 1'b0};
            if (!diff[VALUE_WIDTH])
            begin
                rem_next  = diff[VALUE_WIDTH-1:0];
                qbit_next = 1'b1;
            end
            else
            begin
                rem_next  = trial[VALUE_WIDTH-1:0];
                qbit_next = 1'b0;
            end
        end
    end

    // pick the end the remainder is measured from
    always_comb
    begin
        if (wrap_mode_reg)
        begin
            take_hi = below_reg;
        end
        else
        begin
            take_hi = below_reg ? qbit_reg : !qbit_reg;
        end
        div_res = take_hi ? (hi_reg - $signed(rem_reg)) : (lo_reg + $signed(rem_reg));
    end

    // result register
    always_comb
    begin
        out_next = out_reg;
        if (cmd.publish)
        begin
            if (op_reg == OP_REPEAT)
            begin
                out_next.sample_out = last_reg;
                out_next.zero_span  = 1'b0;
            end
            else if (use_div_reg)
            begin
                out_next.sample_out = div_res;
                out_next.zero_span  = 1'b0;
            end
            else
            begin
                out_next.sample_out = direct_reg;
                out_next.zero_span  = flag_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg     <= in_data.operation;
            sample_reg <= in_data.sample_in;
        end
        if (cmd.setup)
        begin
            lo_reg      <= lo_c;
            hi_reg      <= hi_c;
            span_reg    <= span_c;
            below_reg   <= below_c;
            use_div_reg <= outside_c && (span_c != '0);
            // inside passes through; zero span forces the low bound
            direct_reg  <= outside_c ? lo_c : sample_reg;
            flag_reg    <= outside_c;
        end
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        qbit_reg <= qbit_next;
        out_reg  <= out_next;
    end

    // last mapped value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg <= '0;
        end
        else if (cmd.publish && (op_reg == OP_MAP))
        begin
            last_reg <= out_next.sample_out;
        end
    end

    assign out_data = out_reg;

endmodule

@@ rtl/core/range_fold_wrap.sv @@
// Channel | Signals                           | Moves
// --------+-----------------------------------+---------------------------------
// in      | in_valid, in_ready, in_data       | request: operation, sample_in
// out     | out_valid, out_ready, out_data    | result: sample_out, zero_span
// cfg     | cfg_we, cfg_index, cfg_wdata      | register write, no wait
//
// One request at a time: the result is registered after the setup and output states
// for a repeat, an inside value or a zero span, and after setup, the 32-step restoring
// divider and the output state when a remainder is needed. in_ready returns in the
// same cycle as the result is registered, so no new request is taken before then.
// Reset (rst_n, async, active low) clears control, last result and configuration registers.
// A stalled output holds the datapath in its final step until out_ready.
module range_fold_wrap (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  rfw_pkg::in_item_t               in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output rfw_pkg::out_item_t              out_data,
    input  logic                            cfg_we,
    input  logic [rfw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rfw_pkg::VALUE_WIDTH-1:0] cfg_wdata
);
    import rfw_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    rfw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    rfw_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

@@ tb/range_fold_checker.sv @@
module range_fold_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  rfw_pkg::in_item_t               in_data,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  rfw_pkg::out_item_t              out_data,
    input  logic                            cfg_we,
    input  logic [rfw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rfw_pkg::VALUE_WIDTH-1:0] cfg_wdata,
    output int                              errors,
    output int                              pending,
    output int                              checked,
    output int                              flagged
);

    import rfw_pkg::*;

    typedef logic signed [VALUE_WIDTH-1:0] value_t;

    // Shadow copy of the registers and the repeat buffer
    logic   wrap_sel;
    value_t bound_a;
    value_t bound_b;
    value_t last_result;

    out_item_t expected_results[$];
    int        fail_count   = 0;
    int        result_count = 0;
    int        flag_count   = 0;

    task automatic report_mismatch(string what, logic [VALUE_WIDTH-1:0] got,
                                   logic [VALUE_WIDTH-1:0] want);
        $display("MISMATCH at %0t: %s got %0h, want %0h", $time, what, got, want);
        fail_count++;
    endtask

    // Bring one value into [lo, hi]: fold reflects, wrap restarts at the far end
    function automatic out_item_t fold_or_wrap(value_t n);
        value_t                 lo;
        value_t                 hi;
        logic [VALUE_WIDTH-1:0] span;
        logic [VALUE_WIDTH-1:0] distance;
        logic [VALUE_WIDTH-1:0] rem;
        logic [VALUE_WIDTH-1:0] quo;
        logic                   below;
        logic                   to_high;
        out_item_t              res;
        if (bound_b < bound_a)
        begin
            lo = bound_b;
            hi = bound_a;
        end
        else
        begin
            lo = bound_a;
            hi = bound_b;
        end
        span          = hi - lo;
        res.zero_span = 1'b0;
        if (n >= lo && n <= hi)
            res.sample_out = n;
        else if (span == '0)
        begin
            // degenerate range: clamp to the bound and flag it
            res.sample_out = lo;
            res.zero_span  = 1'b1;
        end
        else
        begin
            below    = (n < lo);
            distance = below ? lo - n : n - hi;
            rem      = distance % span;
            quo      = distance / span;
            // odd number of spans flips the side in fold mode
            to_high        = wrap_sel ? below : (below == quo[0]);
            res.sample_out = to_high ? hi - rem : lo + rem;
        end
        return res;
    endfunction

    // Track register writes, predict on requests, compare on results
    always @(posedge clk or negedge rst_n)
    begin : watch
        out_item_t want;
        out_item_t res;
        if (!rst_n)
        begin
            wrap_sel    = 1'b0;
            bound_a     = BOUND_A_RESET;
            bound_b     = BOUND_B_RESET;
            last_result = '0;
            expected_results.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_WRAP_MODE: wrap_sel = cfg_wdata[0];
                    REG_BOUND_A:   bound_a  = cfg_wdata;
                    REG_BOUND_B:   bound_b  = cfg_wdata;
                    default:       ;
                endcase
            end

            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result, sample_out", out_data.sample_out, '0);
                else
                begin
                    want = expected_results.pop_front();
                    result_count++;
                    if (out_data.zero_span)
                        flag_count++;
                    if (out_data.sample_out !== want.sample_out)
                        report_mismatch("sample_out", out_data.sample_out, want.sample_out);
                    if (out_data.zero_span !== want.zero_span)
                        report_mismatch("zero_span", VALUE_WIDTH'(out_data.zero_span),
                                        VALUE_WIDTH'(want.zero_span));
                end
            end

            if (in_valid && in_ready)
            begin
                if (in_data.operation == OP_REPEAT)
                    expected_results.push_back('{sample_out: last_result, zero_span: 1'b0});
                else
                begin
                    res         = fold_or_wrap(in_data.sample_in);
                    last_result = res.sample_out;
                    expected_results.push_back(res);
                end
            end
        end
        errors  <= fail_count;
        pending <= expected_results.size();
        checked <= result_count;
        flagged <= flag_count;
    end

endmodule

@@ tb/testbench.sv @@
module testbench;

    import rfw_pkg::*;

    localparam int MAX_GAP         = 12;
    localparam int IDLE_LIMIT      = 2000;
    localparam int SETTLE_CYCLES   = 40;
    localparam int RANDOM_REQUESTS = 900;

    // Index past the register list; the block must ignore writes to it
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_ready;
    in_item_t               in_data   = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    out_item_t              out_data;
    logic                   cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [VALUE_WIDTH-1:0] cfg_wdata = '0;

    int errors;
    int pending;
    int checked;
    int flagged;

    int sent        = 0;
    int repeats     = 0;
    int settings    = 0;
    int idle_cycles = 0;
    bit no_idle     = 1'b0;

    // Current range as the stimulus sees it, used to aim samples
    logic signed [VALUE_WIDTH-1:0] cur_lo = '0;
    logic signed [VALUE_WIDTH-1:0] cur_hi = 32'sh0001_0000;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    range_fold_wrap DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    range_fold_checker fold_watch (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .errors    (errors),
        .pending   (pending),
        .checked   (checked),
        .flagged   (flagged)
    );

    // Hang detection: too long without any request or result moving
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles == IDLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Result side: random stall before each result, none in quiet phases
    initial
    begin : ready_driver
        int stall;
        wait (rst_n);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // One request; valid stays up after acceptance unless a gap follows
    task automatic send_request(logic op, logic [VALUE_WIDTH-1:0] value);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{operation: op, sample_in: value};
        sent++;
        if (op == OP_REPEAT)
            repeats++;
        do @(posedge clk); while (!in_ready);
    endtask

    // Stop requesting and wait until every result is back
    task automatic wait_for_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [VALUE_WIDTH-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
    endtask

    // New register setting, written only once the block is idle
    task automatic configure(logic [VALUE_WIDTH-1:0] mode_word, logic [VALUE_WIDTH-1:0] a,
                             logic [VALUE_WIDTH-1:0] b, bit spare);
        wait_for_results();
        write_register(REG_WRAP_MODE, mode_word);
        write_register(REG_BOUND_A, a);
        write_register(REG_BOUND_B, b);
        if (spare)
            write_register(REG_SPARE, $urandom());
        @(posedge clk);
        cfg_we <= 1'b0;
        if ($signed(b) < $signed(a))
        begin
            cur_lo = b;
            cur_hi = a;
        end
        else
        begin
            cur_lo = a;
            cur_hi = b;
        end
        settings++;
    endtask

    // Bounds of several shapes, in either order
    task automatic choose_bounds(output logic [VALUE_WIDTH-1:0] a,
                                 output logic [VALUE_WIDTH-1:0] b);
        logic [VALUE_WIDTH-1:0] t;
        a = $urandom();
        case ($urandom_range(0, 5))
            0: b = a + $urandom_range(1, 16);
            1:
            begin
                a = {{8{a[23]}}, a[23:0]};
                b = a + $urandom_range(1, 32'h0010_0000);
            end
            2: b = $urandom();
            3: b = a;
            4:
            begin
                a = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
                b = ~a ^ $urandom_range(0, 3);
            end
            default: b = a + $urandom_range(1, 2);
        endcase
        if ($urandom_range(0, 1))
        begin
            t = a;
            a = b;
            b = t;
        end
    endtask

    // Sample aimed at the current range: inside, at the edges, some spans out
    function automatic logic [VALUE_WIDTH-1:0] pick_sample();
        logic [VALUE_WIDTH-1:0] span;
        logic [VALUE_WIDTH-1:0] off;
        span = cur_hi - cur_lo;
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: return (span == '1) ? $urandom() : cur_lo + ($urandom() % (span + 1));
            2: return ($urandom_range(0, 1) ? cur_lo : cur_hi) + $urandom_range(0, 6) - 3;
            3:
            begin
                off = span * $urandom_range(0, 6) + ((span == '0) ? '0 : $urandom() % span) + 1;
                return $urandom_range(0, 1) ? cur_lo - off : cur_hi + off;
            end
            default:
            begin
                case ($urandom_range(0, 3))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7FFF_FFFF;
                    2:       return '0;
                    default: return '1;
                endcase
            end
        endcase
    endfunction

    initial
    begin : stimulus
        logic [VALUE_WIDTH-1:0] a;
        logic [VALUE_WIDTH-1:0] b;
        int                     random_sent;
        int                     count;
        random_sent = 0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset setting: fold into [0, 1.0]; repeat before any map gives zero
        send_request(OP_REPEAT, 32'h1234_5678);
        send_request(OP_MAP, 32'h0000_8000);
        send_request(OP_MAP, 32'h0000_0000);
        send_request(OP_MAP, 32'h0001_0000);
        send_request(OP_MAP, 32'h0001_8000);
        send_request(OP_MAP, 32'h0002_8000);
        send_request(OP_MAP, 32'hFFFF_C000);
        send_request(OP_MAP, 32'hFFFE_C000);
        send_request(OP_MAP, 32'h8000_0000);
        send_request(OP_MAP, 32'h7FFF_FFFF);
        send_request(OP_REPEAT, 32'hEDCB_A987);

        // Wrap mode with swapped bounds 3.0 / -2.0
        configure(32'd1, 32'h0003_0000, 32'hFFFE_0000, 1'b0);
        send_request(OP_MAP, 32'h0004_0000);
        send_request(OP_MAP, 32'hFFFD_0000);
        send_request(OP_MAP, 32'h0001_0000);
        send_request(OP_MAP, 32'h8000_0000);
        send_request(OP_MAP, 32'h7FFF_FFFF);

        // Equal bounds: pass-through when equal, flagged clamp otherwise
        configure(32'd0, 32'h0001_2345, 32'h0001_2345, 1'b0);
        send_request(OP_MAP, 32'h0001_2345);
        send_request(OP_MAP, 32'h0000_0000);
        send_request(OP_REPEAT, 32'h0);

        // Folding range one below the widest, bounds given high first
        configure(32'd0, 32'h7FFF_FFFE, 32'h8000_0000, 1'b1);
        send_request(OP_MAP, 32'h7FFF_FFFF);
        send_request(OP_MAP, 32'h8000_0000);
        send_request(OP_MAP, 32'h7FFF_FFFE);

        // Random phases: new setting, then a burst of requests
        while (random_sent < RANDOM_REQUESTS)
        begin
            choose_bounds(a, b);
            configure($urandom(), a, b, $urandom_range(0, 3) == 0);
            no_idle = ($urandom_range(0, 3) == 0);
            count   = $urandom_range(20, 60);
            repeat (count)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_request(OP_REPEAT, $urandom());
                else
                    send_request(OP_MAP, pick_sample());
                random_sent++;
            end
        end

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Ran %0d requests (%0d repeats) across %0d register settings, fold and wrap",
                 sent, repeats, settings);
        $display("Compared %0d results, %0d of them with the zero-span flag set",
                 checked, flagged);
        if (errors == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/rfw_pkg.sv
rtl/core/rfw_ctrl.sv
rtl/core/rfw_dpath.sv
rtl/core/range_fold_wrap.sv
tb/range_fold_checker.sv
tb/testbench.sv
